@@ src/gpl_pkg.sv @@
// ----------------------------------------------------------------------------
// gpl_pkg: shared types and constants of the gpio port
// Register selector codes, access kinds, lock sequence states and the
// request/status structs between the top level and the lock sequencer.
// ----------------------------------------------------------------------------
package gpl_pkg;

  localparam int unsigned PINS       = 16;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned KEY_POS    = 16;
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned PINS_PER_R = 8;

  localparam logic [DATA_W-1:0] MODE_RST = 32'h4444_4444;

  // bus access kind
  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // register selector
  typedef enum logic [2:0] {
    SEL_MODE_LOW  = 3'd0,
    SEL_MODE_HIGH = 3'd1,
    SEL_IN_DATA   = 3'd2,
    SEL_OUT_LATCH = 3'd3,
    SEL_LOCK      = 3'd4
  } reg_sel_t;

  // lock key sequence
  typedef enum logic [2:0] {
    LOCK_IDLE  = 3'd0,
    LOCK_KEY1  = 3'd1,
    LOCK_KEY0  = 3'd2,
    LOCK_KEY2  = 3'd3,
    LOCK_DONE  = 3'd4
  } lock_step_t;

  // one lock register access, already qualified by the transfer
  typedef struct packed {
    logic            wr;
    logic            rd;
    logic            key;
    logic [PINS-1:0] mask;
  } lock_req_t;

  // lock sequencer status
  typedef struct packed {
    logic [PINS-1:0] mask;
    logic            locked;
    logic            locked_nxt;
  } lock_stat_t;

  // expand eight pin lock bits into a nibble protect mask
  function automatic logic [DATA_W-1:0] protect_bits(input logic [PINS_PER_R-1:0] m);
    logic [DATA_W-1:0] p;
    p = '0;
    for (int i = 0; i < PINS_PER_R; i++) begin
      p[i*NIB_W +: NIB_W] = {NIB_W{m[i]}};
    end
    return p;
  endfunction

endpackage

@@ src/gpl_lock.sv @@
// ----------------------------------------------------------------------------
// gpl_lock: lock key sequencer
// Tracks the key write sequence on the lock register, holds the lock mask
// and stays locked until reset once the confirming read has happened.
// ----------------------------------------------------------------------------
module gpl_lock (
  input  logic               clk,
  input  logic               rst_n,
  input  gpl_pkg::lock_req_t req,
  output gpl_pkg::lock_stat_t stat
);
  import gpl_pkg::*;

  lock_step_t      step_r, step_nxt;
  logic [PINS-1:0] mask_r, mask_nxt;
  logic            same;

  assign same = (req.mask == mask_r);

  // next state of the key sequence
  always_comb begin
    step_nxt = step_r;
    unique case (step_r)
      LOCK_DONE: begin
        step_nxt = LOCK_DONE;
      end
      LOCK_KEY1: begin
        if (req.wr) begin
          step_nxt = (!req.key && same) ? LOCK_KEY0 :
                     (req.key ? LOCK_KEY1 : LOCK_IDLE);
        end
      end
      LOCK_KEY0: begin
        if (req.wr) begin
          step_nxt = (req.key && same) ? LOCK_KEY2 :
                     (req.key ? LOCK_KEY1 : LOCK_IDLE);
        end
      end
      LOCK_KEY2: begin
        if (req.wr) begin
          step_nxt = req.key ? LOCK_KEY1 : LOCK_IDLE;
        end else if (req.rd) begin
          step_nxt = LOCK_DONE;
        end
      end
      LOCK_IDLE: begin
        if (req.wr) begin
          step_nxt = req.key ? LOCK_KEY1 : LOCK_IDLE;
        end
      end
      default: begin
        step_nxt = LOCK_IDLE;
      end
    endcase
  end

  // mask follows every lock write until locked
  always_comb begin
    mask_nxt = mask_r;
    if (req.wr && step_r != LOCK_DONE) begin
      mask_nxt = req.mask;
    end
  end

  // status outputs
  always_comb begin
    stat.mask       = mask_r;
    stat.locked     = (step_r == LOCK_DONE);
    stat.locked_nxt = (step_nxt == LOCK_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= LOCK_IDLE;
      mask_r <= '0;
    end else begin
      step_r <= step_nxt;
      mask_r <= mask_nxt;
    end
  end

endmodule

@@ src/gpio_port_with_config_lock.sv @@
// ----------------------------------------------------------------------------
// gpio_port_with_config_lock: 16-pin gpio port with configuration lock
// Bus register block with two mode registers, input data, output latch and
// a key-sequenced lock register.
// ----------------------------------------------------------------------------
// One register access goes in per transfer and one result comes out for
// each. The block takes a new access every cycle; an access is held in an
// input register, executed combinationally against the port state and its
// result lands in an output register, from which its result transfer is made.
// The input register moves on whenever the output register is empty or being
// taken, and the input side only backs up when the output register is full
// and not being taken. The lock register accepts the key sequence (key set,
// key clear, key set, same mask); the next lock read returns key 0 and locks
// the masked mode nibbles until reset.
module gpio_port_with_config_lock (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // write_data[31:0], pin_levels[47:32]
  input  logic [3:0]  in_tuser,   // operation[0], register_select[3:1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // read_data[31:0], pin_drive[47:32],
                                  // lock_active[48], zero[55:49]
);
  import gpl_pkg::*;

  // input register
  logic        in_valid_r;
  logic [47:0] in_data_r;
  logic [3:0]  in_user_r;

  // output register
  logic        out_valid_r;
  logic [55:0] out_data_r;

  // port state
  logic [DATA_W-1:0] mode_low_r, mode_low_nxt;
  logic [DATA_W-1:0] mode_high_r, mode_high_nxt;
  logic [PINS-1:0]   latch_r, latch_nxt;

  logic              advance;
  op_t               op;
  reg_sel_t          sel;
  logic [DATA_W-1:0] wdata;
  logic [PINS-1:0]   pins;
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] prot_low, prot_high;
  lock_req_t         lreq;
  lock_stat_t        lstat;

  // handshake
  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // field unpack
  assign op    = op_t'(in_user_r[0]);
  assign sel   = reg_sel_t'(in_user_r[3:1]);
  assign wdata = in_data_r[31:0];
  assign pins  = in_data_r[47:32];

  // protected nibbles once locked
  assign prot_low  = lstat.locked ? protect_bits(lstat.mask[7:0])  : '0;
  assign prot_high = lstat.locked ? protect_bits(lstat.mask[15:8]) : '0;

  // lock register access
  always_comb begin
    lreq.wr   = advance && (op == OP_WRITE) && (sel == SEL_LOCK);
    lreq.rd   = advance && (op == OP_READ)  && (sel == SEL_LOCK);
    lreq.key  = wdata[KEY_POS];
    lreq.mask = wdata[PINS-1:0];
  end

  gpl_lock u_lock (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (lreq),
    .stat (lstat)
  );

  // register writes
  always_comb begin
    mode_low_nxt  = mode_low_r;
    mode_high_nxt = mode_high_r;
    latch_nxt     = latch_r;
    if (advance && op == OP_WRITE) begin
      unique case (sel)
        SEL_MODE_LOW:  mode_low_nxt  = (mode_low_r & prot_low) | (wdata & ~prot_low);
        SEL_MODE_HIGH: mode_high_nxt = (mode_high_r & prot_high) | (wdata & ~prot_high);
        SEL_OUT_LATCH: latch_nxt     = wdata[PINS-1:0];
        default:       ;
      endcase
    end
  end

  // read mux
  always_comb begin
    rdata = '0;
    if (op == OP_READ) begin
      unique case (sel)
        SEL_MODE_LOW:  rdata = mode_low_r;
        SEL_MODE_HIGH: rdata = mode_high_r;
        SEL_IN_DATA:   rdata = {{(DATA_W-PINS){1'b0}}, pins};
        SEL_OUT_LATCH: rdata = {{(DATA_W-PINS){1'b0}}, latch_r};
        SEL_LOCK:      rdata = {{(DATA_W-PINS-1){1'b0}}, lstat.locked, lstat.mask};
        default:       rdata = '0;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_low_r  <= MODE_RST;
      mode_high_r <= MODE_RST;
      latch_r     <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      mode_low_r  <= mode_low_nxt;
      mode_high_r <= mode_high_nxt;
      latch_r     <= latch_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_user_r <= in_tuser;
    end
    if (advance) begin
      out_data_r <= {7'd0, lstat.locked_nxt, latch_nxt, rdata};
    end
  end

  // once locked, the lock holds until reset
  a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    lstat.locked |=> lstat.locked)
    else $error("lock released without reset");

  // protected low mode nibbles survive a write while locked
  a_mode_low_protect: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && op == OP_WRITE && sel == SEL_MODE_LOW && lstat.locked)
    |=> ((mode_low_r & $past(prot_low)) == ($past(mode_low_r) & $past(prot_low))))
    else $error("locked low mode nibble changed");

  // an empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");

  // lock status in a result matches the sequencer after the access
  a_lock_flag: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_data_r[48] == lstat.locked))
    else $error("result lock flag disagrees with sequencer");

endmodule
